// ===== src/rmq_pkg.sv =====
// Shared types and codes for the retry message queue.
// No dependencies; imported by the core, both checkers and the testbench.
package rmq_pkg;

   typedef enum logic [2:0] {
      FN_LOAD    = 3'd0,
      FN_SEND    = 3'd1,
      FN_TIMEOUT = 3'd2,
      FN_REMOVE  = 3'd3,
      FN_READ    = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_TOO_LONG = 2'd2,
      STS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COPY,
      S_DONE
   } state_type;

endpackage

// ===== src/retry_message_queue_core.sv =====
// Retry message queue core: slot metadata in flip-flops, message bytes in rmq_ram.
// Depends on rmq_pkg and rmq_ram.
//
// Issue an item with start while busy is low. Every item yields exactly one result,
// shown for a single cycle with rsp_valid; the receiver cannot stall it, so capture
// it in that cycle. A new item is accepted only after the result of the last one.
// A read answers from the message RAM in the cycle after the item is accepted.
// A remove, or a timeout that gives up, with more than one message queued compacts
// the queue by copying bytes, slot by slot, through the one read port and one write
// port of the message RAM before the result is shown.
module retry_message_queue_core
   import rmq_pkg::*;
#(
   parameter int SLOTS     = 2,
   parameter int MAX_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_last,
   input  logic [9:0]  req_repeats,
   input  logic [7:0]  req_expected_answer,
   input  logic [23:0] req_timeout_ticks,
   input  logic [7:0]  req_retry_limit,
   input  logic [6:0]  req_read_index,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_slot_index,
   output logic        rsp_tx_start,
   output logic [7:0]  rsp_tx_length,
   output logic [9:0]  rsp_tx_repeats,
   output logic [23:0] rsp_timer_load,
   output logic        rsp_busy_res,
   output logic [7:0]  rsp_head_expected,
   output logic [3:0]  rsp_pending_count,
   output logic        rsp_gave_up,
   output logic [7:0]  rsp_data_byte
);

   localparam int DEPTH = SLOTS * MAX_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(MAX_BYTES + 1);
   localparam int LCW   = $clog2(MAX_BYTES + 2);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMPW  = (LW > 7) ? LW : 7;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [LCW-1:0]   load_cnt_ff, load_cnt_in;
   logic             xmit_ff, xmit_in;
   logic [LW-1:0]    len_ff [SLOTS];
   logic [LW-1:0]    len_in [SLOTS];
   logic [9:0]       rep_ff [SLOTS];
   logic [9:0]       rep_in [SLOTS];
   logic [7:0]       exp_ff [SLOTS];
   logic [7:0]       exp_in [SLOTS];
   logic [23:0]      tmo_ff [SLOTS];
   logic [23:0]      tmo_in [SLOTS];
   logic [7:0]       rty_ff [SLOTS];
   logic [7:0]       rty_in [SLOTS];

   status_type       status_ff, status_in;
   logic [2:0]       slot_ff, slot_in;
   logic             start_ff, start_in;
   logic [23:0]      tload_ff, tload_in;
   logic             gave_ff, gave_in;
   logic             hit_ff, hit_in;

   logic [CW-1:0]    cp_slot_ff, cp_slot_in;
   logic [LW-1:0]    cp_byte_ff, cp_byte_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;

   logic             accept;
   logic             remove_go;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [7:0]       ram_wdata;
   logic             ram_re;
   logic [AW-1:0]    ram_raddr;
   logic [7:0]       ram_rdata;

   function automatic logic [AW-1:0] slot_base(input logic [CW-1:0] s);
      return AW'(int'(s) * MAX_BYTES);
   endfunction

   assign accept = start && (state_ff == S_IDLE);

   rmq_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      logic [LCW-1:0] lc_next;
      logic [SW-1:0]  idx;
      count_in    = count_ff;
      load_cnt_in = load_cnt_ff;
      xmit_in     = xmit_ff;
      len_in      = len_ff;
      rep_in      = rep_ff;
      exp_in      = exp_ff;
      tmo_in      = tmo_ff;
      rty_in      = rty_ff;
      status_in   = status_ff;
      slot_in     = slot_ff;
      start_in    = start_ff;
      tload_in    = tload_ff;
      gave_in     = gave_ff;
      hit_in      = hit_ff;
      cp_slot_in  = cp_slot_ff;
      cp_byte_in  = cp_byte_ff;
      wr_pend_in  = 1'b0;
      wr_addr_in  = wr_addr_ff;
      remove_go   = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = req_msg_byte;
      ram_re      = 1'b0;
      ram_raddr   = '0;
      idx         = count_ff[SW-1:0];
      lc_next     = load_cnt_ff;

      if (accept) begin
         status_in  = STS_OK;
         slot_in    = 3'd0;
         start_in   = 1'b0;
         tload_in   = 24'd0;
         gave_in    = 1'b0;
         hit_in     = 1'b0;
         cp_slot_in = '0;
         cp_byte_in = '0;
         case (req_func)
            FN_LOAD: begin
               if (load_cnt_ff < LCW'(MAX_BYTES) && count_ff < CW'(SLOTS)) begin
                  ram_we    = 1'b1;
                  ram_waddr = slot_base(count_ff) + AW'(load_cnt_ff);
               end
               if (load_cnt_ff <= LCW'(MAX_BYTES)) begin
                  lc_next = load_cnt_ff + 1'b1;
               end
               load_cnt_in = lc_next;
               if (req_last) begin
                  if (lc_next > LCW'(MAX_BYTES)) begin
                     status_in = STS_TOO_LONG;
                  end else if (count_ff == CW'(SLOTS)) begin
                     status_in = STS_FULL;
                  end else begin
                     len_in[idx] = LW'(lc_next);
                     rep_in[idx] = req_repeats;
                     exp_in[idx] = req_expected_answer;
                     tmo_in[idx] = req_timeout_ticks;
                     rty_in[idx] = req_retry_limit;
                     count_in    = count_ff + 1'b1;
                     slot_in     = 3'(count_ff);
                  end
                  load_cnt_in = '0;
               end
            end
            FN_SEND: begin
               if (count_ff == '0) begin
                  status_in = STS_EMPTY;
               end else begin
                  start_in = 1'b1;
                  tload_in = tmo_ff[0];
                  xmit_in  = 1'b1;
               end
            end
            FN_TIMEOUT: begin
               if (count_ff == '0) begin
                  status_in = STS_EMPTY;
               end else if (rty_ff[0] != 8'd0) begin
                  rty_in[0] = rty_ff[0] - 8'd1;
                  start_in  = 1'b1;
                  tload_in  = tmo_ff[0];
               end else begin
                  gave_in   = 1'b1;
                  remove_go = 1'b1;
                  xmit_in   = 1'b0;
               end
            end
            FN_REMOVE: begin
               if (count_ff == '0) begin
                  status_in = STS_EMPTY;
               end else begin
                  remove_go = 1'b1;
               end
               xmit_in = 1'b0;
            end
            FN_READ: begin
               if (count_ff == '0) begin
                  status_in = STS_EMPTY;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = AW'(req_read_index);
                  hit_in    = CMPW'(req_read_index) < CMPW'(len_ff[0]);
               end
            end
            default: begin
            end
         endcase

         if (remove_go) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
               len_in[i] = len_ff[i+1];
               rep_in[i] = rep_ff[i+1];
               exp_in[i] = exp_ff[i+1];
               tmo_in[i] = tmo_ff[i+1];
               rty_in[i] = rty_ff[i+1];
            end
            len_in[SLOTS-1] = '0;
            rep_in[SLOTS-1] = '0;
            exp_in[SLOTS-1] = '0;
            tmo_in[SLOTS-1] = '0;
            rty_in[SLOTS-1] = '0;
            count_in = count_ff - 1'b1;
         end
      end else if (state_ff == S_COPY) begin
         if (wr_pend_ff) begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_ff;
            ram_wdata = ram_rdata;
         end
         if (cp_slot_ff < count_ff) begin
            if (cp_byte_ff < len_ff[cp_slot_ff[SW-1:0]]) begin
               ram_re     = 1'b1;
               ram_raddr  = slot_base(CW'(cp_slot_ff + 1'b1)) + AW'(cp_byte_ff);
               wr_pend_in = 1'b1;
               wr_addr_in = slot_base(cp_slot_ff) + AW'(cp_byte_ff);
               cp_byte_in = cp_byte_ff + 1'b1;
            end else begin
               cp_slot_in = cp_slot_ff + 1'b1;
               cp_byte_in = '0;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (remove_go && count_ff > CW'(1)) begin
                  state_in = S_COPY;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_COPY: begin
            if (cp_slot_ff == count_ff && !wr_pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy              = (state_ff != S_IDLE);
      rsp_valid         = (state_ff == S_DONE);
      rsp_status        = status_ff;
      rsp_slot_index    = slot_ff;
      rsp_tx_start      = start_ff;
      rsp_timer_load    = tload_ff;
      rsp_busy_res      = xmit_ff;
      rsp_gave_up       = gave_ff;
      rsp_pending_count = 4'(count_ff);
      rsp_data_byte     = hit_ff ? ram_rdata : 8'd0;
      if (count_ff != '0) begin
         rsp_tx_length     = 8'(len_ff[0]);
         rsp_tx_repeats    = rep_ff[0];
         rsp_head_expected = exp_ff[0];
      end else begin
         rsp_tx_length     = 8'd0;
         rsp_tx_repeats    = 10'd0;
         rsp_head_expected = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         load_cnt_ff <= '0;
         xmit_ff     <= 1'b0;
         wr_pend_ff  <= 1'b0;
         cp_slot_ff  <= '0;
         cp_byte_ff  <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            len_ff[i] <= '0;
            rep_ff[i] <= '0;
            exp_ff[i] <= '0;
            tmo_ff[i] <= '0;
            rty_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         load_cnt_ff <= load_cnt_in;
         xmit_ff     <= xmit_in;
         wr_pend_ff  <= wr_pend_in;
         cp_slot_ff  <= cp_slot_in;
         cp_byte_ff  <= cp_byte_in;
         len_ff      <= len_in;
         rep_ff      <= rep_in;
         exp_ff      <= exp_in;
         tmo_ff      <= tmo_in;
         rty_ff      <= rty_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      slot_ff    <= slot_in;
      start_ff   <= start_in;
      tload_ff   <= tload_in;
      gave_ff    <= gave_in;
      hit_ff     <= hit_in;
      wr_addr_ff <= wr_addr_in;
   end

endmodule

// ===== src/rmq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== src/rmq_checker.sv =====
// Port-level checks for retry_message_queue_core, bound to every instance.
// Depends on rmq_pkg and retry_message_queue_core.
module rmq_port_checker
   import rmq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic        rsp_tx_start,
   input logic [23:0] rsp_timer_load,
   input logic        rsp_busy_res,
   input logic [3:0]  rsp_pending_count,
   input logic        rsp_gave_up
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 !rsp_valid)
      else $error("result strobe longer than one cycle or outside busy");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_EMPTY |-> rsp_pending_count == 4'd0)
      else $error("empty status with pending messages");

   a_gave_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gave_up |-> !rsp_busy_res && !rsp_tx_start && rsp_timer_load == 24'd0)
      else $error("give-up left transmit active");

endmodule

bind retry_message_queue_core rmq_port_checker u_rmq_checker (.*);

// ===== test/rmq_checker.sv =====
// Result checker for the retry message queue: watches the item and result channels,
// keeps its own model of the slots and message bytes, and compares each result.
// Depends on rmq_pkg.
module rmq_checker
   import rmq_pkg::*;
#(
   parameter int SLOTS     = 2,
   parameter int MAX_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_last,
   input  logic [9:0]  req_repeats,
   input  logic [7:0]  req_expected_answer,
   input  logic [23:0] req_timeout_ticks,
   input  logic [7:0]  req_retry_limit,
   input  logic [6:0]  req_read_index,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [2:0]  rsp_slot_index,
   input  logic        rsp_tx_start,
   input  logic [7:0]  rsp_tx_length,
   input  logic [9:0]  rsp_tx_repeats,
   input  logic [23:0] rsp_timer_load,
   input  logic        rsp_busy_res,
   input  logic [7:0]  rsp_head_expected,
   input  logic [3:0]  rsp_pending_count,
   input  logic        rsp_gave_up,
   input  logic [7:0]  rsp_data_byte,
   output int          mismatches,
   output int          awaiting
);

   typedef struct packed {
      status_type  status;
      logic [2:0]  slot_index;
      logic        tx_start;
      logic [7:0]  tx_length;
      logic [9:0]  tx_repeats;
      logic [23:0] timer_load;
      logic        busy_res;
      logic [7:0]  head_expected;
      logic [3:0]  pending_count;
      logic        gave_up;
      logic [7:0]  data_byte;
   } rsp_fields_type;

   logic [7:0]     msg_mem [SLOTS*MAX_BYTES];
   logic           slot_used [SLOTS];
   int             slot_len [SLOTS];
   logic [9:0]     slot_rep [SLOTS];
   logic [7:0]     slot_answer [SLOTS];
   logic [23:0]    slot_ticks [SLOTS];
   logic [7:0]     slot_tries [SLOTS];
   int             bytes_in;
   logic           sending;
   rsp_fields_type queued_rsp [$];

   function automatic int oldest_slot();
      int s;
      for (s = 0; s < SLOTS; s++)
         if (slot_used[s]) return s;
      return SLOTS;
   endfunction

   function automatic void clear_slot(int s);
      slot_used[s]   = 1'b0;
      slot_len[s]    = 0;
      slot_rep[s]    = '0;
      slot_answer[s] = '0;
      slot_ticks[s]  = '0;
      slot_tries[s]  = '0;
   endfunction

   function automatic void compact_from(int s);
      int i, k;
      for (i = s; i + 1 < SLOTS; i++) begin
         if (slot_used[i+1]) begin
            for (k = 0; k < slot_len[i+1] && k < MAX_BYTES; k++)
               msg_mem[i*MAX_BYTES + k] = msg_mem[(i+1)*MAX_BYTES + k];
            slot_used[i]   = 1'b1;
            slot_len[i]    = slot_len[i+1];
            slot_rep[i]    = slot_rep[i+1];
            slot_answer[i] = slot_answer[i+1];
            slot_ticks[i]  = slot_ticks[i+1];
            slot_tries[i]  = slot_tries[i+1];
         end else begin
            clear_slot(i);
         end
      end
      clear_slot(SLOTS - 1);
   endfunction

   function automatic rsp_fields_type queue_step(logic [2:0] fn, logic [7:0] b, logic lst,
                                                 logic [9:0] rp, logic [7:0] ea,
                                                 logic [23:0] tm, logic [7:0] rl,
                                                 logic [6:0] ri);
      rsp_fields_type r;
      int h, f, n;
      r = '0;
      h = oldest_slot();
      case (fn)
         FN_LOAD: begin
            f = SLOTS;
            for (n = SLOTS - 1; n >= 0; n--)
               if (!slot_used[n]) f = n;
            if (bytes_in < MAX_BYTES && f < SLOTS)
               msg_mem[f*MAX_BYTES + bytes_in] = b;
            if (bytes_in <= MAX_BYTES) bytes_in++;
            if (lst) begin
               if (bytes_in > MAX_BYTES) begin
                  r.status = STS_TOO_LONG;
               end else if (f >= SLOTS) begin
                  r.status = STS_FULL;
               end else begin
                  slot_used[f]   = 1'b1;
                  slot_len[f]    = bytes_in;
                  slot_rep[f]    = rp;
                  slot_answer[f] = ea;
                  slot_ticks[f]  = tm;
                  slot_tries[f]  = rl;
                  r.slot_index   = 3'(f);
               end
               bytes_in = 0;
            end
         end
         FN_SEND: begin
            if (h >= SLOTS) begin
               r.status = STS_EMPTY;
            end else begin
               r.tx_start   = 1'b1;
               r.timer_load = slot_ticks[h];
               sending      = 1'b1;
            end
         end
         FN_TIMEOUT: begin
            if (h >= SLOTS) begin
               r.status = STS_EMPTY;
            end else if (slot_tries[h] != 0) begin
               slot_tries[h] = slot_tries[h] - 8'd1;
               r.tx_start    = 1'b1;
               r.timer_load  = slot_ticks[h];
            end else begin
               r.gave_up = 1'b1;
               compact_from(h);
               sending = 1'b0;
            end
         end
         FN_REMOVE: begin
            if (h >= SLOTS) r.status = STS_EMPTY;
            else compact_from(h);
            sending = 1'b0;
         end
         FN_READ: begin
            if (h >= SLOTS) r.status = STS_EMPTY;
            else if (ri < slot_len[h] && ri < MAX_BYTES)
               r.data_byte = msg_mem[h*MAX_BYTES + ri];
         end
         default: ;
      endcase
      h = oldest_slot();
      n = 0;
      for (f = 0; f < SLOTS; f++)
         if (slot_used[f]) n++;
      r.busy_res      = sending;
      r.pending_count = 4'(n);
      if (h < SLOTS) begin
         r.tx_length     = 8'(slot_len[h]);
         r.tx_repeats    = slot_rep[h];
         r.head_expected = slot_answer[h];
      end
      return r;
   endfunction

   always @(posedge clock) begin : track
      rsp_fields_type want, got;
      int k;
      if (reset) begin
         for (k = 0; k < SLOTS*MAX_BYTES; k++) msg_mem[k] = '0;
         for (k = 0; k < SLOTS; k++) clear_slot(k);
         bytes_in   = 0;
         sending    = 1'b0;
         mismatches = 0;
         queued_rsp.delete();
      end else begin
         if (start && !busy)
            queued_rsp.push_back(queue_step(req_func, req_msg_byte, req_last, req_repeats,
                                            req_expected_answer, req_timeout_ticks,
                                            req_retry_limit, req_read_index));
         if (rsp_valid) begin
            got.status        = status_type'(rsp_status);
            got.slot_index    = rsp_slot_index;
            got.tx_start      = rsp_tx_start;
            got.tx_length     = rsp_tx_length;
            got.tx_repeats    = rsp_tx_repeats;
            got.timer_load    = rsp_timer_load;
            got.busy_res      = rsp_busy_res;
            got.head_expected = rsp_head_expected;
            got.pending_count = rsp_pending_count;
            got.gave_up       = rsp_gave_up;
            got.data_byte     = rsp_data_byte;
            if (queued_rsp.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result with no item outstanding", $realtime);
               mismatches++;
            end else begin
               want = queued_rsp.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("%0t: exp sts=%0d slot=%0d txs=%b len=%0d rep=%0d tmr=%h bsy=%b",
                              $realtime, want.status, want.slot_index, want.tx_start,
                              want.tx_length, want.tx_repeats, want.timer_load,
                              want.busy_res);
                     $display("        exp head=%h cnt=%0d gave=%b data=%h",
                              want.head_expected, want.pending_count, want.gave_up,
                              want.data_byte);
                     $display("        got sts=%0d slot=%0d txs=%b len=%0d rep=%0d tmr=%h bsy=%b",
                              got.status, got.slot_index, got.tx_start, got.tx_length,
                              got.tx_repeats, got.timer_load, got.busy_res);
                     $display("        got head=%h cnt=%0d gave=%b data=%h",
                              got.head_expected, got.pending_count, got.gave_up,
                              got.data_byte);
                  end
                  mismatches++;
               end
            end
         end
      end
      awaiting = queued_rsp.size();
   end

endmodule

// ===== test/tb_retry_message_queue_core.sv =====
// Testbench top for retry_message_queue_core: clock, reset, directed and random items.
// Depends on rmq_pkg, retry_message_queue_core and rmq_checker, which judges each result.
module tb_retry_message_queue_core
   import rmq_pkg::*;
();

   localparam int          SLOT_COUNT      = 2;
   localparam int          MSG_BYTES       = 128;
   localparam int          RANDOM_ITEMS    = 1400;
   localparam int          CYCLE_LIMIT     = 1_000_000;
   localparam int          DRAIN_CYCLES    = 200;
   localparam logic [2:0]  FN_UNUSED_FIRST = 3'd5;
   localparam logic [2:0]  FN_UNUSED_LAST  = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_func = '0;
   logic [7:0]  req_msg_byte = '0;
   logic        req_last = 1'b0;
   logic [9:0]  req_repeats = '0;
   logic [7:0]  req_expected_answer = '0;
   logic [23:0] req_timeout_ticks = '0;
   logic [7:0]  req_retry_limit = '0;
   logic [6:0]  req_read_index = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_slot_index;
   logic        rsp_tx_start;
   logic [7:0]  rsp_tx_length;
   logic [9:0]  rsp_tx_repeats;
   logic [23:0] rsp_timer_load;
   logic        rsp_busy_res;
   logic [7:0]  rsp_head_expected;
   logic [3:0]  rsp_pending_count;
   logic        rsp_gave_up;
   logic [7:0]  rsp_data_byte;

   int   mismatches;
   int   awaiting;
   int   cycles = 0;
   int   items_sent = 0;
   logic item_taken = 1'b0;
   bit   quiet = 1'b0;

   always #5 clock = ~clock;

   retry_message_queue_core #(
      .SLOTS(SLOT_COUNT),
      .MAX_BYTES(MSG_BYTES)
   ) dut (.*);

   rmq_checker #(
      .SLOTS(SLOT_COUNT),
      .MAX_BYTES(MSG_BYTES)
   ) scoreboard (.*);

   always @(posedge clock) item_taken <= start && !busy;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // call at a falling edge; returns at a falling edge after acceptance, sometimes after a random pause
   task automatic put_item(input logic [2:0] fn, input logic [7:0] b, input logic lst,
                           input logic [9:0] rp, input logic [7:0] ea,
                           input logic [23:0] tm, input logic [7:0] rl,
                           input logic [6:0] ri);
      req_func            <= fn;
      req_msg_byte        <= b;
      req_last            <= lst;
      req_repeats         <= rp;
      req_expected_answer <= ea;
      req_timeout_ticks   <= tm;
      req_retry_limit     <= rl;
      req_read_index      <= ri;
      start               <= 1'b1;
      do @(negedge clock); while (!item_taken);
      items_sent++;
      if (!quiet && $urandom_range(0, 99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   task automatic put_op(input logic [2:0] fn, input logic [6:0] ri);
      put_item(fn, 8'($urandom), 1'($urandom), 10'($urandom), 8'($urandom),
               24'($urandom), 8'($urandom), ri);
   endtask

   // attributes count only on the last byte; with interleave set, inject remove or timeout mid-message at random
   task automatic load_message(input int len, input logic [9:0] rp, input logic [7:0] ea,
                               input logic [23:0] tm, input logic [7:0] rl,
                               input bit interleave);
      for (int k = 0; k < len; k++) begin
         if (interleave && $urandom_range(0, 19) == 0)
            put_op($urandom_range(0, 1) ? FN_REMOVE : FN_TIMEOUT, 7'($urandom));
         if (k == len - 1)
            put_item(FN_LOAD, 8'($urandom), 1'b1, rp, ea, tm, rl, 7'($urandom));
         else
            put_item(FN_LOAD, 8'($urandom), 1'b0, 10'($urandom), 8'($urandom),
                     24'($urandom), 8'($urandom), 7'($urandom));
      end
   endtask

   initial begin
      int         pick, len, base;
      logic [7:0] tries;
      logic [6:0] idx;
      bit         paused;
      paused = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      put_op(FN_SEND, 7'd0);
      put_op(FN_TIMEOUT, 7'd0);
      put_op(FN_READ, 7'd0);
      put_op(FN_REMOVE, 7'd0);
      for (int u = FN_UNUSED_FIRST; u <= FN_UNUSED_LAST; u++) put_op(3'(u), 7'($urandom));

      // fill every byte of both slots before any read reaches the store
      load_message(MSG_BYTES, 10'h3FF, 8'hFF, 24'hFFFFFF, 8'hFF, 1'b0);
      load_message(MSG_BYTES + 2, 10'h3FF, 8'hFF, 24'hFFFFFF, 8'hFF, 1'b0);
      load_message(MSG_BYTES, 10'd0, 8'd0, 24'd0, 8'd0, 1'b0);
      load_message(2, 10'd5, 8'h5A, 24'h000100, 8'd1, 1'b0);
      load_message(MSG_BYTES + 1, 10'd1, 8'h01, 24'h000001, 8'd1, 1'b0);
      put_op(FN_READ, 7'd0);
      put_op(FN_READ, 7'h7F);
      put_op(FN_SEND, 7'd0);
      put_op(FN_SEND, 7'd0);
      put_op(FN_TIMEOUT, 7'd0);
      put_op(FN_REMOVE, 7'd0);
      put_op(FN_READ, 7'h7F);
      put_op(FN_TIMEOUT, 7'd0);
      put_op(FN_REMOVE, 7'd0);
      load_message(1, 10'd7, 8'h3C, 24'h00ABCD, 8'd1, 1'b0);
      put_op(FN_READ, 7'd5);
      put_op(FN_READ, 7'd0);
      put_op(FN_SEND, 7'd0);
      put_op(FN_TIMEOUT, 7'd0);
      put_op(FN_TIMEOUT, 7'd0);

      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         quiet = (items_sent - base >= 300) && (items_sent - base < 650);
         if (!paused && items_sent - base >= RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            while (awaiting != 0) @(negedge clock);
            paused = 1'b1;
            @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            len = $urandom_range(0, 99);
            if (len < 80) len = $urandom_range(1, 8);
            else if (len < 95) len = $urandom_range(9, MSG_BYTES);
            else len = $urandom_range(MSG_BYTES + 1, MSG_BYTES + 3);
            tries = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            load_message(len, 10'($urandom), 8'($urandom), 24'($urandom), tries, 1'b1);
         end else if (pick < 50) begin
            put_op(FN_SEND, 7'($urandom));
         end else if (pick < 65) begin
            put_op(FN_TIMEOUT, 7'($urandom));
         end else if (pick < 75) begin
            put_op(FN_REMOVE, 7'($urandom));
         end else if (pick < 93) begin
            idx = ($urandom_range(0, 99) < 60) ? 7'($urandom_range(0, 7)) : 7'($urandom);
            put_op(FN_READ, idx);
         end else begin
            put_op(3'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST)), 7'($urandom));
         end
      end
      start <= 1'b0;

      while (awaiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
src/rmq_pkg.sv
src/rmq_ram.sv
src/retry_message_queue_core.sv
src/rmq_checker.sv
test/rmq_checker.sv
test/tb_retry_message_queue_core.sv
